// ===== design/cgc_pkg.sv =====
// Shared types and constants for the conflict graph first-fit coloring block.
// No dependencies; every other file imports this package.
package cgc_pkg;

	localparam int USERS     = 8;
	localparam int FILES     = 16;
	localparam int CHUNKS    = 8;
	localparam int MAX_NODES = 256;

	localparam int USER_W    = $clog2(USERS);
	localparam int FILE_W    = $clog2(FILES);
	localparam int CHUNK_W   = $clog2(CHUNKS);
	localparam int COLOR_W   = 9;
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int CACHE_DEPTH = USERS * FILES * CHUNKS;
	localparam int CACHE_AW  = $clog2(CACHE_DEPTH);

	// taken flags cover colors 1..MAX_NODES, scanned one group per cycle
	localparam int TAKEN_N   = MAX_NODES;
	localparam int GRP_SIZE  = 16;
	localparam int GROUPS    = TAKEN_N / GRP_SIZE;
	localparam int GRP_W     = $clog2(GROUPS);
	localparam int GRP_POS_W = $clog2(GRP_SIZE);
	localparam logic [COLOR_W-1:0] COLOR_NONE = COLOR_W'(TAKEN_N + 1);

	typedef enum logic [1:0] {
		KIND_CACHE    = 2'd0,
		KIND_PRECOLOR = 2'd1,
		KIND_COLOR    = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [USER_W-1:0]  user;
		logic [FILE_W-1:0]  file;
		logic [CHUNK_W-1:0] chunk;
		logic [COLOR_W-1:0] color;
	} node_t;

	typedef struct packed {
		logic               clear;
		logic               mark;
		logic [COLOR_W-1:0] mark_color;
		logic               scan;
	} srch_ctl_t;

	typedef struct packed {
		logic               done;
		logic [COLOR_W-1:0] color;
	} srch_stat_t;

endpackage

// ===== design/cgc_if.sv =====
// Request and response channel interfaces (valid/ready) for the coloring block.
// Depends on cgc_pkg for field widths.
interface cgc_req_if import cgc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [USER_W-1:0]  user;
	logic [FILE_W-1:0]  file;
	logic [CHUNK_W-1:0] chunk;
	logic               cached;
	logic [COLOR_W-1:0] given_color;

	modport source (output valid, kind, user, file, chunk, cached, given_color, input ready);
	modport sink   (input valid, kind, user, file, chunk, cached, given_color, output ready);
endinterface

interface cgc_rsp_if import cgc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] node_color;
	logic               new_color;
	logic [COLOR_W-1:0] color_count;
	logic               store_full;

	modport source (output valid, node_color, new_color, color_count, store_full,
		input ready);
	modport sink   (input valid, node_color, new_color, color_count, store_full,
		output ready);
endinterface

// ===== design/conflict_graph_first_fit_coloring.sv =====
// First-fit coloring of a chunk-request conflict graph.
// Depends on cgc_pkg, cgc_if, cgc_cache_mem, cgc_node_mem, cgc_color_search.
//
// Usage:
//   req: valid/ready items. kind 0 writes a cache bit, kind 3 empties the
//   node store; both give no result. kind 1 stores a
//   precolored node; kind 2 colors a node with the smallest free color.
//   rsp: one item per kind 1/2 request, held in an output register until
//   taken.
//   cfg_we/cfg_wdata: loads the initial color count (also the running count).
// Sequence:
//   kind 2 walks the store through the shared conflict compare (node read,
//   cache read, mark), then scans for a free color, 16 flags per cycle,
//   then loads the output register. kind 1 stores the node, then loads the
//   output register.
//   req.ready is high only while the sequencer is idle.
// Reset: node store empty, counts zero. Cache and node memories are not
//   cleared. If rsp stalls, a finished item waits in the sequencer until the
//   output register frees.
module conflict_graph_first_fit_coloring import cgc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cgc_req_if.sink            req,
	cgc_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_SEARCH, ST_EMIT} state_t;

	state_t             state_q;
	logic [COLOR_W-1:0] init_q;
	logic [COLOR_W-1:0] colors_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic               v_s1;
	logic               v_s2;
	logic               rsp_valid_q;

	logic [USER_W-1:0]  user_q;
	logic [FILE_W-1:0]  file_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [COLOR_W-1:0] color_s2;
	logic               same_s2;

	logic [COLOR_W-1:0] res_color_q;
	logic               res_new_q;
	logic [COLOR_W-1:0] res_count_q;
	logic               res_full_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_new_q;
	logic [COLOR_W-1:0] out_count_q;
	logic               out_full_q;

	logic       accept;
	logic       is_node;
	logic       store_ok;
	logic       nre;
	logic       cache_we;
	logic       bit_a;
	logic       bit_b;
	logic       conflict;
	logic       fin_full;
	logic       fin_pre;
	logic       fin_fit;
	logic       newc;
	logic       emit;
	logic       nwe;
	node_t      nwdata;
	node_t      nd_rd;
	srch_ctl_t  sctl;
	srch_stat_t sstat;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_node   = (req.kind == KIND_PRECOLOR) || (req.kind == KIND_COLOR);
	assign store_ok  = (count_q != CNT_W'(MAX_NODES));
	assign cache_we  = accept && (req.kind == KIND_CACHE);
	assign nre       = (state_q == ST_WALK) && (idx_q < count_q);
	assign conflict  = v_s2 && !same_s2 && (!bit_a || !bit_b);

	assign fin_full = accept && is_node && !store_ok;
	assign fin_pre  = accept && (req.kind == KIND_PRECOLOR) && store_ok;
	assign fin_fit  = (state_q == ST_SEARCH) && sstat.done;
	assign newc     = sstat.color > colors_q;
	assign emit     = (state_q == ST_EMIT) && (!rsp_valid_q || rsp.ready);

	assign sctl.clear      = accept && (req.kind == KIND_COLOR);
	assign sctl.mark       = conflict;
	assign sctl.mark_color = color_s2;
	assign sctl.scan       = (state_q == ST_SEARCH);

	assign nwe = fin_pre || fin_fit;
	always_comb begin
		if (fin_pre) begin
			nwdata = '{user: req.user, file: req.file, chunk: req.chunk,
				color: req.given_color};
		end else begin
			nwdata = '{user: user_q, file: file_q, chunk: chunk_q, color: sstat.color};
		end
	end

	cgc_cache_mem u_cache (
		.clk     (clk),
		.we      (cache_we),
		.waddr   ({req.user, req.file, req.chunk}),
		.wdata   (req.cached),
		.re      (v_s1),
		.raddr_a ({nd_rd.user, file_q, chunk_q}),
		.raddr_b ({user_q, nd_rd.file, nd_rd.chunk}),
		.rdata_a (bit_a),
		.rdata_b (bit_b)
	);

	cgc_node_mem u_nodes (
		.clk   (clk),
		.we    (nwe),
		.waddr (count_q[NODE_AW-1:0]),
		.wdata (nwdata),
		.re    (nre),
		.raddr (idx_q[NODE_AW-1:0]),
		.rdata (nd_rd)
	);

	cgc_color_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.stat   (sstat)
	);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.node_color  = out_color_q;
	assign rsp.new_color   = out_new_q;
	assign rsp.color_count = out_count_q;
	assign rsp.store_full  = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_q      <= '0;
			colors_q    <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= nre;
			v_s2 <= v_s1;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				init_q   <= cfg_wdata;
				colors_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.kind)
							KIND_CLEAR: begin
								count_q  <= '0;
								colors_q <= init_q;
							end
							KIND_PRECOLOR: begin
								if (store_ok) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_EMIT;
							end
							KIND_COLOR: begin
								idx_q   <= '0;
								state_q <= store_ok ? ST_WALK : ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (nre) begin
						idx_q <= idx_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (sstat.done) begin
						count_q <= count_q + 1'b1;
						if (newc) begin
							colors_q <= sstat.color;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		color_s2 <= nd_rd.color;
		same_s2  <= (nd_rd.file == file_q) && (nd_rd.chunk == chunk_q);
		if (accept) begin
			user_q  <= req.user;
			file_q  <= req.file;
			chunk_q <= req.chunk;
		end
		if (fin_full) begin
			res_color_q <= '0;
			res_new_q   <= 1'b0;
			res_count_q <= colors_q;
			res_full_q  <= 1'b1;
		end else if (fin_pre) begin
			res_color_q <= req.given_color;
			res_new_q   <= 1'b0;
			res_count_q <= colors_q;
			res_full_q  <= 1'b0;
		end else if (fin_fit) begin
			res_color_q <= sstat.color;
			res_new_q   <= newc;
			res_count_q <= newc ? sstat.color : colors_q;
			res_full_q  <= 1'b0;
		end
		if (emit) begin
			out_color_q <= res_color_q;
			out_new_q   <= res_new_q;
			out_count_q <= res_count_q;
			out_full_q  <= res_full_q;
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond store depth");

	a_s2_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_WALK)
		else $error("conflict pipeline active outside walk");

	a_fit_stores: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fit |=> count_q == $past(count_q) + 1'b1)
		else $error("colored node not stored");

	a_new_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && out_new_q) |-> out_color_q == out_count_q)
		else $error("new color differs from color count");

endmodule

// ===== design/cgc_cache_mem.sv =====
// Cache indicator bit table: one write port, two registered read ports.
// Depends on cgc_pkg.
module cgc_cache_mem import cgc_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [CACHE_AW-1:0] waddr,
	input  logic                wdata,
	input  logic                re,
	input  logic [CACHE_AW-1:0] raddr_a,
	input  logic [CACHE_AW-1:0] raddr_b,
	output logic                rdata_a,
	output logic                rdata_b
);

	logic mem [CACHE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== design/cgc_node_mem.sv =====
// Graph node store: one write port, one registered read port.
// Depends on cgc_pkg for node_t.
module cgc_node_mem import cgc_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [NODE_AW-1:0] waddr,
	input  node_t              wdata,
	input  logic               re,
	input  logic [NODE_AW-1:0] raddr,
	output node_t              rdata
);

	node_t mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/cgc_color_search.sv =====
// Taken-color flags and first-free search, one group of flags per cycle.
// Depends on cgc_pkg for srch_ctl_t / srch_stat_t.
module cgc_color_search import cgc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  srch_ctl_t  ctl,
	output srch_stat_t stat
);

	logic [TAKEN_N-1:0]   taken_q;
	logic [GRP_W-1:0]     grp_q;
	logic [GRP_SIZE-1:0]  free;
	logic                 hit;
	logic [GRP_POS_W-1:0] pos;
	logic [COLOR_W-1:0]   midx;
	logic                 mark_ok;

	always_comb begin
		free = ~taken_q[{grp_q, {GRP_POS_W{1'b0}}} +: GRP_SIZE];
		hit  = 1'b0;
		pos  = '0;
		for (int k = GRP_SIZE - 1; k >= 0; k--) begin
			if (free[k]) begin
				hit = 1'b1;
				pos = GRP_POS_W'(k);
			end
		end
	end

	assign stat.done  = hit || (grp_q == GRP_W'(GROUPS - 1));
	assign stat.color = hit ? (COLOR_W'({grp_q, pos}) + 1'b1) : COLOR_NONE;

	assign midx    = ctl.mark_color - 1'b1;
	assign mark_ok = ctl.mark && (ctl.mark_color != '0)
		&& (ctl.mark_color <= COLOR_W'(TAKEN_N));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			grp_q   <= '0;
		end else if (ctl.clear) begin
			taken_q <= '0;
			grp_q   <= '0;
		end else begin
			if (mark_ok) begin
				taken_q[midx[NODE_AW-1:0]] <= 1'b1;
			end
			if (ctl.scan && !hit) begin
				grp_q <= grp_q + 1'b1;
			end
		end
	end

endmodule
